// ===== hdl/lwfr_pkg.sv =====
// Package for the line-of-sight weighting function recurrence core.
// Holds the item type, operation codes, sequencer states and fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package lwfr_pkg;

  localparam logic [24:0] ONE_TR = 25'h1000000;
  localparam int NUM_W = 57;
  localparam int DEN_W = 25;
  localparam logic [5:0] DIV_STEPS = 6'd57;
  localparam logic signed [31:0] W_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] W_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    OP_NEAR  = 2'd0,
    OP_INNER = 2'd1,
    OP_FAR   = 2'd2,
    OP_SKIP  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [9:0]         ch;
    logic signed [31:0] meas;
    logic [24:0]        tr;
    logic signed [31:0] s1;
    logic signed [31:0] sq;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIVS,
    ST_DIVW,
    ST_SUM,
    ST_MT,
    ST_ML0,
    ST_ML1,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/los_weighting_function_recurrence_core.sv =====
// Top level of the line-of-sight weighting function recurrence core.
// Depends on lwfr_pkg, lwfr_front, lwfr_queue and lwfr_back.
//
// Channel   Dir  Bits                Contents
// s_axis    in   tdata 136, tuser 2  channel, radiance, transmission, sources; operation
// m_axis    out  tdata 48, tuser 1   channel, weight; saturated flag
// cfg       in   31                  path step, unsigned Q15.16
//
// A request holds the back end from queue pop to the next pop; the 57-step
// restoring divider that peels each layer sets how long, and far-point and
// zero-transmission requests skip it. A stalled output holds the back end
// longer. The front end keeps accepting into a two-entry queue until it is
// full, while the back end works or waits on a stalled output. Reset is
// synchronous; per-channel stores are not cleared, and the user must read
// them only after a nearest-point request wrote them; the core does not enforce this.
`timescale 1ns / 1ps

module los_weighting_function_recurrence_core import lwfr_pkg::*; #(
  parameter int CHANNELS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [30:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // channel[9:0], measured_radiance[41:10], layer_transmission[66:42],
  // source_near[98:67], source_here[130:99], zero fill above.
  input  logic [135:0] s_axis_tdata,
  // operation[1:0].
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_channel[9:0], weight[41:10], zero fill above.
  output logic [47:0]  m_axis_tdata,
  // saturated[0].
  output logic         m_axis_tuser
);

  logic  q_full;
  logic  q_push;
  logic  q_valid;
  logic  q_pop;
  item_t q_in;
  item_t q_out;

  lwfr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  lwfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .full     (q_full),
    .valid    (q_valid),
    .item_out (q_out),
    .pop      (q_pop)
  );

  lwfr_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_valid       (q_valid),
    .q_item        (q_out),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== hdl/lwfr_front.sv =====
// Front end: accepts input requests, clamps transmission, drops skip codes.
// Depends on lwfr_pkg.
`timescale 1ns / 1ps

module lwfr_front import lwfr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         q_full,
  output logic         q_push,
  output item_t        q_item
);

  logic [24:0] tr_in;
  logic        accept;

  assign s_axis_tready = !q_full && !rst;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign tr_in = s_axis_tdata[66:42];

  always_comb begin
    q_item.op = op_t'(s_axis_tuser);
    q_item.ch = s_axis_tdata[9:0];
    q_item.meas = s_axis_tdata[41:10];
    q_item.tr = (tr_in > ONE_TR) ? ONE_TR : tr_in;
    q_item.s1 = s_axis_tdata[98:67];
    q_item.sq = s_axis_tdata[130:99];
  end

  assign q_push = accept && (op_t'(s_axis_tuser) != OP_SKIP);

endmodule

// ===== hdl/lwfr_queue.sv =====
// Two-entry queue of classified items between front end and sequencer.
// Depends on lwfr_pkg.
`timescale 1ns / 1ps

module lwfr_queue import lwfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item_in,
  output logic  full,
  output logic  valid,
  output item_t item_out,
  input  logic  pop
);

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign item_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/lwfr_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on lwfr_pkg.
`timescale 1ns / 1ps

module lwfr_div import lwfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_r;
  logic [5:0]       cnt;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem[DEN_W-1:0], quo[NUM_W-1]};
  assign fits = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, den_r}) : shifted;
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/lwfr_back.sv =====
// Back end: per-channel stores, arithmetic sequencer and output register.
// Depends on lwfr_pkg and lwfr_div.
`timescale 1ns / 1ps

module lwfr_back import lwfr_pkg::*; #(
  parameter int CHANNELS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state;
  state_t state_next;

  logic [24:0]        t_mem [CHANNELS];
  logic signed [31:0] y_mem [CHANNELS];
  logic [24:0]        t_rd;
  logic signed [31:0] y_rd;

  item_t              it;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      head_idx;
  logic [26:0]        red;
  logic [30:0]        path_step;
  logic signed [31:0] y_r;
  logic [24:0]        t_r;
  logic signed [57:0] num_r;
  logic signed [34:0] p2_r;
  logic [24:0]        t_new_r;
  logic signed [31:0] y_new_r;
  logic               num_neg;
  logic               sum_neg;
  logic [34:0]        sum_mag;
  logic [34:0]        a_r;
  logic [65:0]        acc_r;
  logic               flag_r;

  logic               rd_en;
  logic               div_start;
  logic               out_load;
  logic               div_busy;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;

  logic [24:0]        tr_comp;
  logic signed [57:0] s1_prod;
  logic signed [32:0] dys;
  logic [32:0]        dmag;
  logic [57:0]        pm_full;
  logic [33:0]        pm;
  logic [57:0]        num_abs;
  logic signed [36:0] sum_c;
  logic [36:0]        sum_abs;
  logic [59:0]        at_full;
  logic [49:0]        tt_full;
  logic [48:0]        wmag;
  logic signed [31:0] w_out;
  logic               w_sat;

  always_comb begin
    red = {17'd0, q_item.ch};
    for (int k = 9; k >= 0; k--) begin
      if (red >= (27'(CHANNELS) << k)) begin
        red = red - (27'(CHANNELS) << k);
      end
    end
    head_idx = red[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) state_next = ST_READ;
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL: state_next = ST_DIVS;
      ST_DIVS: begin
        if (it.op == OP_FAR || it.tr == 25'd0) state_next = ST_SUM;
        else state_next = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) state_next = ST_SUM;
      end
      ST_SUM: state_next = ST_MT;
      ST_MT: state_next = ST_ML0;
      ST_ML0: state_next = ST_ML1;
      ST_ML1: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    rd_en = 1'b0;
    div_start = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_pop = q_valid;
        rd_en = q_valid;
      end
      ST_DIVS: div_start = (it.op != OP_FAR) && (it.tr != 25'd0);
      ST_DONE: out_load = !m_axis_tvalid || m_axis_tready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      t_rd <= t_mem[head_idx];
      y_rd <= y_mem[head_idx];
    end
    if (out_load && it.op != OP_FAR) begin
      t_mem[idx_r] <= (it.op == OP_NEAR) ? it.tr : t_new_r;
      y_mem[idx_r] <= y_new_r;
    end
  end

  lwfr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_abs[NUM_W-1:0]),
    .den   (it.tr),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign tr_comp = ONE_TR - it.tr;
  assign s1_prod = it.s1 * $signed({1'b0, tr_comp});
  assign dys = 33'(y_r) - 33'(it.s1);
  assign dmag = dys[32] ? 33'(-dys) : 33'(dys);
  assign pm_full = 58'(dmag) * 58'(it.tr);
  assign pm = pm_full[57:24];
  assign tt_full = 50'(t_r) * 50'(it.tr);
  assign num_abs = num_r[57] ? 58'(-num_r) : 58'(num_r);

  always_comb begin
    unique case (it.op)
      OP_NEAR: sum_c = 37'(y_new_r) - 37'(it.s1);
      OP_INNER: sum_c = (37'(p2_r) <<< 1) + 37'(it.s1) - 37'(it.sq);
      default: sum_c = 37'(y_r) - 37'(it.s1);
    endcase
    sum_abs = sum_c[36] ? 37'(-sum_c) : 37'(sum_c);
  end

  assign at_full = 60'(sum_mag) * 60'(t_r);
  assign wmag = acc_r[65:17];

  always_comb begin
    w_sat = 1'b0;
    if (sum_neg) begin
      if (wmag > 49'h7FFFFFFF) begin
        w_out = W_MAX;
        w_sat = 1'b1;
      end else begin
        w_out = $signed(wmag[31:0]);
      end
    end else begin
      if (wmag > 49'h80000000) begin
        w_out = W_MIN;
        w_sat = 1'b1;
      end else begin
        w_out = $signed(-wmag[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      it <= q_item;
      idx_r <= head_idx;
    end
    unique case (state)
      ST_READ: begin
        y_r <= (it.op == OP_NEAR) ? it.meas : y_rd;
        t_r <= (it.op == OP_NEAR) ? it.tr : t_rd;
      end
      ST_MUL: begin
        num_r <= (58'(y_r) <<< 24) - s1_prod;
        p2_r <= dys[32] ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
        t_new_r <= tt_full[48:24];
      end
      ST_DIVS: begin
        num_neg <= num_r[57];
        if (it.op != OP_FAR && it.tr == 25'd0) begin
          y_new_r <= num_r[57] ? W_MIN : W_MAX;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          if (!num_neg) begin
            y_new_r <= (div_quo > 57'h7FFFFFFF) ? W_MAX : $signed(div_quo[31:0]);
          end else begin
            y_new_r <= (div_quo > 57'h80000000) ? W_MIN : $signed(-div_quo[31:0]);
          end
        end
      end
      ST_SUM: begin
        sum_neg <= sum_c[36];
        sum_mag <= sum_abs[34:0];
      end
      ST_MT: a_r <= at_full[58:24];
      ST_ML0: acc_r <= 66'(a_r[17:0]) * 66'(path_step);
      ST_ML1: acc_r <= acc_r + ((66'(a_r[34:18]) * 66'(path_step)) << 18);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_r <= 1'b0;
    end else if (q_pop) begin
      flag_r <= 1'b0;
    end else if (state == ST_DIVS && it.op != OP_FAR && it.tr == 25'd0) begin
      flag_r <= 1'b1;
    end else if (state == ST_DIVW && div_done) begin
      if ((!num_neg && div_quo > 57'h7FFFFFFF) || (num_neg && div_quo > 57'h80000000)) begin
        flag_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_step <= 31'd65536;
    end else if (cfg_we) begin
      path_step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {6'd0, w_out, it.ch};
      m_axis_tuser <= flag_r || w_sat;
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");
  a_store_ops: assert property (@(posedge clk) disable iff (rst)
    (out_load && it.op != OP_FAR) |-> (it.op == OP_NEAR || it.op == OP_INNER))
    else $error("store written by a far-point request");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVW && div_done) |=> state == ST_SUM)
    else $error("sequencer missed divider completion");

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for the line-of-sight weighting function recurrence core.
// Drives path samples over the input stream and compares weights with an internal predictor.
// Depends on lwfr_pkg and los_weighting_function_recurrence_core.
`timescale 1ns / 1ps

module testbench;
  import lwfr_pkg::*;

  localparam int NCH = 1024;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [9:0]         ch;
    logic signed [31:0] w;
    logic               sat;
  } weight_t;

  typedef struct {
    op_t                op;
    logic [9:0]         ch;
    logic signed [31:0] meas;
    logic [24:0]        tr;
    logic signed [31:0] s1;
    logic signed [31:0] sq;
    logic               known;
    logic signed [31:0] w;
    logic               sat;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic m_axis_tuser;

  los_weighting_function_recurrence_core #(.CHANNELS(NCH)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [24:0] trans_store [NCH];
  logic signed [63:0] rad_store [NCH];
  logic [30:0] step_len = 31'd65536;
  weight_t pending_weights[$];
  int errors = 0;
  int weights_seen = 0;
  int requests_sent = 0;
  int idle_cycles = 0;
  bit out_calm = 1'b0;
  bit in_calm = 1'b0;
  bit [3:0] ops_seen = '0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] scale_trunc(input logic signed [63:0] a,
      input logic [63:0] b, input int sh);
    logic [63:0] mag, hi, lo, r;
    mag = (a < 0) ? -a : a;
    hi = mag >> sh;
    lo = mag & ((64'd1 << sh) - 1);
    r = hi * b + ((lo * b) >> sh);
    return (a < 0) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] peel_layer(input logic signed [63:0] y,
      input logic signed [63:0] s, input logic [24:0] tr, inout bit f);
    logic signed [63:0] num;
    num = y * 64'sd16777216 - s * (64'sd16777216 - $signed({39'd0, tr}));
    if (tr == 0) begin
      f = 1'b1;
      return (num >= 0) ? 64'sd2147483647 : -64'sd2147483648;
    end
    return clip32(num / $signed({39'd0, tr}), f);
  endfunction

  function automatic logic signed [63:0] weight_from(input logic signed [63:0] sum,
      input logic [24:0] t, inout bit f);
    logic signed [63:0] a;
    a = scale_trunc(sum, {39'd0, t}, 24);
    return clip32(-scale_trunc(a, {33'd0, step_len}, 17), f);
  endfunction

  function automatic bit predict_weight(input item_t it, output weight_t res);
    bit f;
    logic [24:0] tr, t;
    logic signed [63:0] y, s1, sq, w;
    f = 1'b0;
    if (it.op == OP_SKIP) return 1'b0;
    tr = (it.tr > ONE_TR) ? ONE_TR : it.tr;
    s1 = it.s1;
    sq = it.sq;
    if (it.op == OP_NEAR) begin
      y = peel_layer(it.meas, s1, tr, f);
      w = weight_from(y - s1, tr, f);
      trans_store[it.ch] = tr;
      rad_store[it.ch] = y;
    end else begin
      y = rad_store[it.ch];
      t = trans_store[it.ch];
      if (it.op == OP_INNER) begin
        w = weight_from(2 * scale_trunc(y - s1, {39'd0, tr}, 24) + s1 - sq, t, f);
        trans_store[it.ch] = ({39'd0, t} * {39'd0, tr}) >> 24;
        rad_store[it.ch] = peel_layer(y, s1, tr, f);
      end else begin
        w = weight_from(y - s1, t, f);
      end
    end
    res.ch = it.ch;
    res.w = w[31:0];
    res.sat = f;
    return 1'b1;
  endfunction

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(input item_t it, input bit known,
      input logic signed [31:0] kw, input bit ksat);
    weight_t res;
    while (!in_calm && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.op;
    s_axis_tdata <= {5'd0, it.sq, it.s1, it.tr, it.meas, it.ch};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
    ops_seen[it.op] = 1'b1;
    if (predict_weight(it, res)) begin
      if (known && (res.w !== kw || res.sat !== ksat))
        report($sformatf("predictor disagrees with table row ch %0d", it.ch));
      if (known) begin
        res.w = kw;
        res.sat = ksat;
      end
      pending_weights.push_back(res);
    end
  endtask

  task automatic drain_then_write(input logic [30:0] v);
    stop_input();
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_len = v;
  endtask

  always @(posedge clk) begin
    weight_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[9:0], m_axis_tdata[41:10], m_axis_tuser};
        weights_seen++;
        if (pending_weights.size() == 0) begin
          report("weight with nothing expected");
        end else begin
          want = pending_weights.pop_front();
          if (got.ch !== want.ch)
            report($sformatf("channel %0d, expected %0d", got.ch, want.ch));
          if (got.w !== want.w)
            report($sformatf("ch %0d weight %h, expected %h", want.ch, got.w, want.w));
          if (got.sat !== want.sat)
            report($sformatf("ch %0d saturated %b, expected %b", want.ch, got.sat, want.sat));
        end
      end
      m_axis_tready <= out_calm || ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t mk(input op_t op, input logic [9:0] ch,
      input logic [31:0] m, input logic [24:0] tr, input logic [31:0] s1,
      input logic [31:0] sq);
    item_t it;
    it.op = op; it.ch = ch; it.meas = m; it.tr = tr; it.s1 = s1; it.sq = sq;
    return it;
  endfunction

  function automatic logic [24:0] rand_tr();
    case ($urandom_range(9))
      0: return '0;
      1: return ONE_TR;
      2: return 25'($urandom);
      3: return 25'(ONE_TR - $urandom_range(255));
      default: return 25'($urandom_range(16777216, 8388608));
    endcase
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1, 0) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  row_t rows [17] = '{
    '{OP_NEAR, 10'd0, 32'sd0, 25'h1000000, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b0},
    '{OP_FAR, 10'd0, 32'sd0, 25'h1000000, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b0},
    '{OP_NEAR, 10'd1, 32'sd65536, 25'h1000000, 32'sd0, 32'sd0, 1'b1, -32'sd32768, 1'b0},
    '{OP_INNER, 10'd1, 32'sd0, 25'h0800000, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{OP_INNER, 10'd1, 32'sd0, 25'h1FFFFFF, -32'sd70000, 32'sd5000, 1'b0, 32'sd0, 1'b0},
    '{OP_FAR, 10'd1, 32'sd0, 25'h0, 32'sd1234, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{OP_NEAR, 10'd1023, 32'sh7FFFFFFF, 25'h0, 32'sd0, 32'sd0, 1'b1, -32'sd0, 1'b1},
    '{OP_NEAR, 10'd1022, 32'sh80000000, 25'h0, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b1},
    '{OP_INNER, 10'd1023, 32'sh7FFFFFFF, 25'h0, 32'sh80000000, 32'sh7FFFFFFF, 1'b0,
      32'sd0, 1'b0},
    '{OP_FAR, 10'd1023, 32'sd0, 25'h1000000, 32'sh80000000, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{OP_SKIP, 10'd511, 32'sh7FFFFFFF, 25'h1FFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0,
      32'sd0, 1'b0},
    '{OP_NEAR, 10'd512, 32'sh80000000, 25'h0000001, 32'sh7FFFFFFF, 32'sh80000000, 1'b0,
      32'sd0, 1'b0},
    '{OP_INNER, 10'd512, 32'sd0, 25'h0000001, 32'sh7FFFFFFF, 32'sh80000000, 1'b0,
      32'sd0, 1'b0},
    '{OP_FAR, 10'd512, 32'sd0, 25'h1FFFFFF, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{OP_NEAR, 10'd341, 32'sd100000, 25'h0C00000, 32'sd20000, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{OP_INNER, 10'd341, 32'sd0, 25'h0E00000, 32'sd30000, 32'sd40000, 1'b0, 32'sd0, 1'b0},
    '{OP_FAR, 10'd341, 32'sd0, 25'h0, 32'sd10000, 32'sd0, 1'b0, 32'sd0, 1'b0}
  };

  initial begin
    item_t it;
    logic [9:0] chans [4];
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      it = mk(rows[i].op, rows[i].ch, rows[i].meas, rows[i].tr, rows[i].s1, rows[i].sq);
      send_request(it, rows[i].known, rows[i].w, rows[i].sat);
    end
    drain_then_write(31'h7FFFFFFF);
    n = 0;
    while (n < 400) begin
      if (n == 152) drain_then_write(31'd0);
      if (n == 260) drain_then_write(31'($urandom));
      if (n == 332) drain_then_write(31'd65536);
      in_calm = (n >= 100 && n < 140);
      out_calm = (n >= 100 && n < 140);
      if ($urandom_range(9) == 0) begin
        it = mk(OP_SKIP, 10'($urandom), $urandom, 25'($urandom), $urandom, $urandom);
        send_request(it, 1'b0, 0, 1'b0);
        continue;
      end
      if (n == 200) begin
        stop_input();
        while (pending_weights.size() != 0) @(posedge clk);
      end
      foreach (chans[k])
        chans[k] = (k != 0 && $urandom_range(3) == 0) ? chans[0] : 10'($urandom);
      foreach (chans[k]) begin
        send_request(mk(OP_NEAR, chans[k], rand_val(), rand_tr(), rand_val(), 0),
                     1'b0, 0, 1'b0);
        n++;
      end
      repeat ($urandom_range(4)) begin
        foreach (chans[k]) begin
          send_request(mk(OP_INNER, chans[k], $urandom, rand_tr(), rand_val(), rand_val()),
                       1'b0, 0, 1'b0);
          n++;
        end
      end
      foreach (chans[k]) begin
        send_request(mk(OP_FAR, chans[k], $urandom, 25'($urandom), rand_val(), $urandom),
                     1'b0, 0, 1'b0);
        n++;
      end
    end
    stop_input();
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Run covered %0d requests and %0d weights, operations seen %b.",
             requests_sent, weights_seen, ops_seen);
    $display("Path step went through reset, zero, maximum and random settings.");
    if (errors == 0 && pending_weights.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
